[src/alphabet_radix_counter_assert.svh]
// Assertion macros for the alphabet radix counter
`ifndef ALPHABET_RADIX_COUNTER_ASSERT_SVH
`define ALPHABET_RADIX_COUNTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during reset
`define ARC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, clocked on clk, off during reset
`define ARC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ARC_ASSERT_IMP(lbl, ante, cons, msg)
`define ARC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[src/arc_pkg.sv]
// Shared constants, codes and command/status types of the alphabet radix counter
`timescale 1ns / 1ps

package arc_pkg;

	// sizing
	localparam int DIGITS   = 8;
	localparam int SYMBOLS  = 256;
	localparam int CAPACITY = (SYMBOLS > 255) ? 255 : SYMBOLS;
	localparam int BYTE_W   = 8;
	localparam int WORD_W   = 64;
	localparam int WORD_BYTES = WORD_W / BYTE_W;
	localparam int DIG_IW   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int SYM_AW   = $clog2(SYMBOLS);
	localparam int BYTE_VALS = 1 << BYTE_W;
	// divider: dividend is the increment plus one digit, one bit wider
	localparam int DIV_W    = WORD_W + 1;
	localparam int BIT_W    = $clog2(DIV_W);

	// actions
	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_RADIX_LOW = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic append;
		logic div_load;
		logic div_step;
		logic sym_rd;
		logic sym_cap;
		logic lk_rd;
		logic lk_cap;
		logic out_load;
	} arc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic radix_lt2;
		logic bit_last;
		logic dig_last;
		logic out_free;
	} arc_sts_t;

endpackage

[src/arc_in_if.sv]
// Input channel: one item word with valid/ready
`timescale 1ns / 1ps

interface arc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  symbol_byte;
	logic [63:0] digit_word;
	logic [63:0] increment;

	modport source (output valid, output action, output symbol_byte,
		output digit_word, output increment, input ready);
	modport sink (input valid, input action, input symbol_byte,
		input digit_word, input increment, output ready);
endinterface

[src/arc_out_if.sv]
// Output channel: one result word with valid/ready
`timescale 1ns / 1ps

interface arc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_digits;
	logic [63:0] result_symbols;
	logic [7:0]  symbol_count;
	logic [1:0]  status;

	modport source (output valid, output result_digits, output result_symbols,
		output symbol_count, output status, input ready);
	modport sink (input valid, input result_digits, input result_symbols,
		input symbol_count, input status, output ready);
endinterface

[src/arc_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module arc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/arc_ctrl.sv]
// Controller: sequences append, per-digit divide/add and lookup steps
`timescale 1ns / 1ps

module arc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic [1:0]         item_action,
	output logic               item_ready,
	input  arc_pkg::arc_sts_t  sts,
	output arc_pkg::arc_cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_APPEND   = 9'b000000010,
		S_ADD_LOAD = 9'b000000100,
		S_ADD_DIV  = 9'b000001000,
		S_ADD_SYM  = 9'b000010000,
		S_ADD_CAP  = 9'b000100000,
		S_LK_RD    = 9'b001000000,
		S_LK_CAP   = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					case (item_action)
						arc_pkg::ACT_APPEND: state_d = S_APPEND;
						arc_pkg::ACT_ADD:    state_d = sts.radix_lt2 ? S_DONE : S_ADD_LOAD;
						arc_pkg::ACT_LOOKUP: state_d = S_LK_RD;
						default:             state_d = S_DONE;
					endcase
				end
			end
			S_APPEND:   state_d = S_DONE;
			S_ADD_LOAD: state_d = S_ADD_DIV;
			S_ADD_DIV: begin
				if (sts.bit_last) state_d = S_ADD_SYM;
			end
			S_ADD_SYM:  state_d = S_ADD_CAP;
			S_ADD_CAP:  state_d = sts.dig_last ? S_DONE : S_ADD_LOAD;
			S_LK_RD:    state_d = S_LK_CAP;
			S_LK_CAP:   state_d = sts.dig_last ? S_DONE : S_LK_RD;
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// commands
	assign item_ready   = (state_q == S_IDLE);
	assign cmd.load     = (state_q == S_IDLE) && item_valid;
	assign cmd.append   = (state_q == S_APPEND);
	assign cmd.div_load = (state_q == S_ADD_LOAD);
	assign cmd.div_step = (state_q == S_ADD_DIV);
	assign cmd.sym_rd   = (state_q == S_ADD_SYM);
	assign cmd.sym_cap  = (state_q == S_ADD_CAP);
	assign cmd.lk_rd    = (state_q == S_LK_RD);
	assign cmd.lk_cap   = (state_q == S_LK_CAP);
	assign cmd.out_load = (state_q == S_DONE) && sts.out_free;

endmodule

[src/arc_dp.sv]
// Datapath: alphabet tables, bit-serial divider, digit assembly, result register
`timescale 1ns / 1ps

module arc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  arc_pkg::arc_cmd_t  cmd,
	output arc_pkg::arc_sts_t  sts,
	input  logic [1:0]         action,
	input  logic [7:0]         symbol_byte,
	input  logic [63:0]        digit_word,
	input  logic [63:0]        increment,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        result_digits,
	output logic [63:0]        result_symbols,
	output logic [7:0]         symbol_count,
	output logic [1:0]         status
);

	// item registers
	logic [arc_pkg::DIGITS-1:0][arc_pkg::BYTE_W-1:0]     word_q;
	logic [arc_pkg::WORD_W-1:0]                          inc_q;
	logic [arc_pkg::BYTE_W-1:0]                          sym_q;
	logic [arc_pkg::DIG_IW-1:0]                          dig_q;
	logic [arc_pkg::WORD_BYTES-1:0][arc_pkg::BYTE_W-1:0] res_dig_q;
	logic [arc_pkg::WORD_BYTES-1:0][arc_pkg::BYTE_W-1:0] res_sym_q;
	logic [1:0]                                          status_q;

	// alphabet state
	logic [arc_pkg::BYTE_W-1:0]    radix_q;
	logic [arc_pkg::BYTE_VALS-1:0] present_q;

	// divider
	logic [arc_pkg::DIV_W-1:0]  div_q;
	logic [arc_pkg::BYTE_W-1:0] rem_q;
	logic [arc_pkg::BIT_W-1:0]  bit_q;
	logic [arc_pkg::BYTE_W:0]   rem_sh;
	logic [arc_pkg::BYTE_W:0]   rem_sub;
	logic                       rem_ge;

	// result register
	logic        out_valid_q;
	logic [63:0] out_dig_q;
	logic [63:0] out_sym_q;
	logic [7:0]  out_cnt_q;
	logic [1:0]  out_status_q;

	logic [arc_pkg::BYTE_W-1:0] cur_byte;
	logic                       append_ok;
	logic [arc_pkg::BYTE_W-1:0] sym_rdata;
	logic [arc_pkg::BYTE_W-1:0] idx_rdata;

	assign cur_byte  = word_q[dig_q];
	assign append_ok = cmd.append && !present_q[sym_q]
		&& (radix_q < arc_pkg::BYTE_W'(arc_pkg::CAPACITY));

	// digit -> symbol
	arc_ram #(.WIDTH(arc_pkg::BYTE_W), .DEPTH(arc_pkg::SYMBOLS)) u_sym_ram (
		.clk   (clk),
		.we    (append_ok),
		.waddr (radix_q[arc_pkg::SYM_AW-1:0]),
		.wdata (sym_q),
		.raddr (rem_q[arc_pkg::SYM_AW-1:0]),
		.rdata (sym_rdata)
	);

	// symbol -> digit; lookup returns zero for entries without a presence bit
	arc_ram #(.WIDTH(arc_pkg::BYTE_W), .DEPTH(arc_pkg::BYTE_VALS)) u_idx_ram (
		.clk   (clk),
		.we    (append_ok),
		.waddr (sym_q),
		.wdata (radix_q),
		.raddr (cur_byte),
		.rdata (idx_rdata)
	);

	// one restoring divide step
	assign rem_sh  = {rem_q, div_q[arc_pkg::DIV_W-1]};
	assign rem_ge  = (rem_sh >= {1'b0, radix_q});
	assign rem_sub = rem_sh - {1'b0, radix_q};

	// alphabet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q   <= '0;
			present_q <= '0;
		end else if (append_ok) begin
			radix_q            <= radix_q + 8'd1;
			present_q[sym_q]   <= 1'b1;
		end
	end

	// item work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q    <= digit_word[arc_pkg::DIGITS*arc_pkg::BYTE_W-1:0];
			inc_q     <= increment;
			sym_q     <= symbol_byte;
			dig_q     <= '0;
			res_dig_q <= '0;
			res_sym_q <= '0;
			status_q  <= (action == arc_pkg::ACT_ADD && radix_q < 8'd2)
				? arc_pkg::STATUS_RADIX_LOW : arc_pkg::STATUS_OK;
		end
		if (cmd.append && !present_q[sym_q] && !append_ok) begin
			status_q <= arc_pkg::STATUS_FULL;
		end
		// dividend is increment plus digit; quotient is the next increment
		if (cmd.div_load) begin
			div_q <= {1'b0, inc_q} + arc_pkg::DIV_W'(cur_byte);
			rem_q <= '0;
			bit_q <= '0;
		end
		if (cmd.div_step) begin
			div_q <= {div_q[arc_pkg::DIV_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_sub[arc_pkg::BYTE_W-1:0] : rem_sh[arc_pkg::BYTE_W-1:0];
			bit_q <= bit_q + 1'b1;
		end
		if (cmd.sym_rd) begin
			res_dig_q[dig_q] <= rem_q;
			inc_q            <= div_q[arc_pkg::WORD_W-1:0];
		end
		if (cmd.sym_cap) begin
			res_sym_q[dig_q] <= sym_rdata;
			dig_q            <= dig_q + 1'b1;
		end
		if (cmd.lk_cap) begin
			res_dig_q[dig_q] <= present_q[cur_byte] ? idx_rdata : '0;
			dig_q            <= dig_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_dig_q    <= res_dig_q;
			out_sym_q    <= res_sym_q;
			out_cnt_q    <= radix_q;
			out_status_q <= status_q;
		end
	end

	// status to controller
	assign sts.radix_lt2 = (radix_q < 8'd2);
	assign sts.bit_last  = (bit_q == arc_pkg::BIT_W'(arc_pkg::DIV_W - 1));
	assign sts.dig_last  = (dig_q == arc_pkg::DIG_IW'(arc_pkg::DIGITS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign result_digits  = out_dig_q;
	assign result_symbols = out_sym_q;
	assign symbol_count   = out_cnt_q;
	assign status         = out_status_q;

endmodule

[src/alphabet_radix_counter.sv]
// Top level of the alphabet radix counter: controller, datapath and assertions
`timescale 1ns / 1ps

// Builds an alphabet of distinct bytes (append), adds a binary increment into
// an eight-digit little-endian word whose radix is the alphabet size (add), and
// maps symbol bytes back to digit indices (lookup). One result word per item.
// Items are handled one at a time; the next item is taken once the current one
// has reached the result register, which may still be waiting on the sink.
// In an add, each digit goes through one bit-serial restoring divider, one
// quotient bit per cycle over a 65-bit dividend, followed by a symbol table
// read. An add with fewer than two symbols returns at once with status 2. No
// clearing pass is needed after reset.
`include "alphabet_radix_counter_assert.svh"

module alphabet_radix_counter (
	input logic       clk,
	input logic       arst_n,
	arc_in_if.sink    item,
	arc_out_if.source result
);

	arc_pkg::arc_cmd_t cmd;
	arc_pkg::arc_sts_t sts;

	arc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_action (item.action),
		.item_ready  (item.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	arc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (item.action),
		.symbol_byte    (item.symbol_byte),
		.digit_word     (item.digit_word),
		.increment      (item.increment),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.result_digits  (result.result_digits),
		.result_symbols (result.result_symbols),
		.symbol_count   (result.symbol_count),
		.status         (result.status)
	);

	// checks
	`ARC_ASSERT_IMP(a_cmd_excl, 1'b1, $onehot0({cmd.append, cmd.div_load, cmd.div_step, cmd.sym_rd, cmd.sym_cap, cmd.lk_rd, cmd.lk_cap, cmd.out_load}), "more than one datapath command")
	`ARC_ASSERT_NXT(a_busy_after_accept, item.valid && item.ready, !item.ready, "item taken while busy")
	`ARC_ASSERT_IMP(a_radix_cap, result.valid, result.symbol_count <= 8'(arc_pkg::CAPACITY), "alphabet beyond capacity")
	`ARC_ASSERT_IMP(a_low_radix_zero, result.valid && result.status == arc_pkg::STATUS_RADIX_LOW, result.result_digits == '0 && result.result_symbols == '0 && result.symbol_count < 8'd2, "low-radix add result not empty")

endmodule
